// ----- hdl/http_header_line_parser_top_macros.svh -----
// Assertion macros shared by the parser's checks
`ifndef HTTP_HEADER_LINE_PARSER_TOP_MACROS_SVH
`define HTTP_HEADER_LINE_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HHLP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define HHLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/hhlp_pkg.sv -----
`default_nettype none
package hhlp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ClassW = 4;
  localparam int unsigned StateW = 4;

  // Parse states
  localparam logic [StateW-1:0] ST_START  = 4'd0;
  localparam logic [StateW-1:0] ST_KEY    = 4'd1;
  localparam logic [StateW-1:0] ST_SPACES = 4'd2;
  localparam logic [StateW-1:0] ST_VALUE  = 4'd3;
  localparam logic [StateW-1:0] ST_CR     = 4'd4;
  localparam logic [StateW-1:0] ST_LF     = 4'd5;
  localparam logic [StateW-1:0] ST_END_CR = 4'd6;
  localparam logic [StateW-1:0] ST_BODY   = 4'd7;
  localparam logic [StateW-1:0] ST_STOP   = 4'd8;
  localparam logic [StateW-1:0] ST_BAD    = 4'd9;

  // Byte classes
  localparam logic [ClassW-1:0] CL_SKIP    = 4'd0;
  localparam logic [ClassW-1:0] CL_KEY     = 4'd1;
  localparam logic [ClassW-1:0] CL_COLON   = 4'd2;
  localparam logic [ClassW-1:0] CL_VALUE   = 4'd3;
  localparam logic [ClassW-1:0] CL_VCR     = 4'd4;
  localparam logic [ClassW-1:0] CL_COMMIT  = 4'd5;
  localparam logic [ClassW-1:0] CL_HEND    = 4'd6;
  localparam logic [ClassW-1:0] CL_BODY    = 4'd7;
  localparam logic [ClassW-1:0] CL_DISCARD = 4'd8;

  // Characters of interest
  localparam logic [ByteW-1:0] CH_COLON = 8'h3A;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
  localparam logic [ByteW-1:0] CH_NUL   = 8'h00;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [ClassW-1:0] class_t;
  typedef logic [StateW-1:0] state_t;

endpackage
`default_nettype wire

// ----- hdl/hhlp_in_if.sv -----
`default_nettype none
interface hhlp_in_if
  import hhlp_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  first_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input first_byte, input last_byte,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/hhlp_out_if.sv -----
`default_nettype none
interface hhlp_out_if
  import hhlp_pkg::*;
;
  logic   valid;
  logic   ready;
  byte_t  echo_byte;
  class_t byte_class;
  logic   malformed;
  logic   end_of_buffer;

  modport source (output valid, output echo_byte, output byte_class, output malformed,
                  output end_of_buffer, input ready);
  modport sink (input valid, input echo_byte, input byte_class, input malformed,
                input end_of_buffer, output ready);
endinterface
`default_nettype wire

// ----- hdl/http_header_line_parser_top.sv -----
// HTTP header line parser: tags each byte of a response buffer with its place in the
// header (skipped, key, colon, value, line ends, header end, body, discarded) and flags
// a broken CRLF pair. Every accepted byte yields exactly one result, in the next cycle,
// from the result register; a new byte is accepted every cycle while the result register
// is empty or being taken, so the sustained rate is one byte per cycle. first_byte
// restarts the parser before its byte is handled, and after a byte with last_byte set
// the parser returns to its start state.
`default_nettype none
`include "http_header_line_parser_top_macros.svh"
module http_header_line_parser_top
  import hhlp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  hhlp_in_if.sink     in_ch,
  hhlp_out_if.source  out_ch
);

  state_t parse_state;
  state_t parse_state_next;
  state_t st_cur;
  state_t st_step;
  class_t cls;
  logic   bad;
  logic   in_accept;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    st_cur = parse_state;
    if (in_ch.first_byte || (parse_state > ST_BAD)) begin
      st_cur = ST_START;
    end
    st_step = st_cur;
    cls     = CL_DISCARD;
    bad     = 1'b0;
    if (st_cur == ST_BAD) begin
      bad = 1'b1;
    end else if ((st_cur == ST_STOP) || (in_ch.data_byte == CH_NUL)) begin
      st_step = ST_STOP;
    end else begin
      unique case (st_cur)
        ST_START: begin
          if ((in_ch.data_byte == CH_CR) || (in_ch.data_byte == CH_LF)) begin
            cls = CL_SKIP;
          end else begin
            cls     = CL_KEY;
            st_step = ST_KEY;
          end
        end
        ST_KEY: begin
          if (in_ch.data_byte == CH_COLON) begin
            cls     = CL_COLON;
            st_step = ST_SPACES;
          end else begin
            cls = CL_KEY;
          end
        end
        ST_SPACES: begin
          if (in_ch.data_byte == CH_SPACE) begin
            cls = CL_SKIP;
          end else if (in_ch.data_byte == CH_CR) begin
            cls     = CL_VCR;
            st_step = ST_CR;
          end else begin
            cls     = CL_VALUE;
            st_step = ST_VALUE;
          end
        end
        ST_VALUE: begin
          if (in_ch.data_byte == CH_CR) begin
            cls     = CL_VCR;
            st_step = ST_CR;
          end else begin
            cls = CL_VALUE;
          end
        end
        ST_CR: begin
          if (in_ch.data_byte == CH_LF) begin
            cls     = CL_COMMIT;
            st_step = ST_LF;
          end else begin
            bad     = 1'b1;
            st_step = ST_BAD;
          end
        end
        ST_LF: begin
          if (in_ch.data_byte == CH_CR) begin
            cls     = CL_HEND;
            st_step = ST_END_CR;
          end else begin
            cls     = CL_KEY;
            st_step = ST_KEY;
          end
        end
        ST_END_CR: begin
          if (in_ch.data_byte == CH_LF) begin
            cls     = CL_HEND;
            st_step = ST_BODY;
          end else begin
            bad     = 1'b1;
            st_step = ST_BAD;
          end
        end
        default: begin
          cls = CL_BODY;
        end
      endcase
    end
    // buffer end: start the next buffer clean
    parse_state_next = in_ch.last_byte ? ST_START : st_step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state  <= ST_START;
      out_ch.valid <= 1'b0;
    end else begin
      if (in_accept) begin
        parse_state  <= parse_state_next;
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // result payload: load on every accepted transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_ch.echo_byte     <= in_ch.data_byte;
      out_ch.byte_class    <= cls;
      out_ch.malformed     <= bad;
      out_ch.end_of_buffer <= in_ch.last_byte;
    end
  end

  `HHLP_ASSERT_NEXT(a_accept_loads_result, clk, rst, in_accept, out_ch.valid,
                    "accepted byte left no result")
  `HHLP_ASSERT_NOW(a_malformed_is_discard, clk, rst, out_ch.valid && out_ch.malformed,
                   out_ch.byte_class == CL_DISCARD, "malformed result not tagged discard")
  `HHLP_ASSERT_NEXT(a_bad_stays_bad, clk, rst,
                    in_accept && !in_ch.first_byte && (parse_state == ST_BAD),
                    out_ch.malformed, "byte after broken CRLF not flagged malformed")
  `HHLP_ASSERT_NEXT(a_last_returns_start, clk, rst, in_accept && in_ch.last_byte,
                    parse_state == ST_START, "parser not back at start after buffer end")

endmodule
`default_nettype wire

// ----- bench/hhlp_checker.sv -----
`timescale 1ns / 100ps
module hhlp_checker
  import hhlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  hhlp_in_if         in_ch,
  hhlp_out_if        out_ch,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    byte_t  echo;
    class_t cls;
    logic   bad;
    logic   eob;
  } tag_t;

  state_t parse_st;
  tag_t   tags_due[$];

  function automatic tag_t tag_byte(input byte_t b, input logic f, input logic l,
                                    input state_t cur, output state_t nxt);
    tag_t   t;
    state_t st;
    st = f ? ST_START : cur;
    if (st > ST_BAD) st = ST_START;
    t.echo = b;
    t.bad  = 1'b0;
    t.eob  = l;
    t.cls  = CL_DISCARD;
    if (st == ST_BAD) begin
      t.bad = 1'b1;
    end else if (st == ST_STOP || b == CH_NUL) begin
      st = ST_STOP;
    end else begin
      case (st)
        ST_START: begin
          if (b == CH_CR || b == CH_LF) begin
            t.cls = CL_SKIP;
          end else begin
            t.cls = CL_KEY;
            st = ST_KEY;
          end
        end
        ST_KEY: begin
          if (b == CH_COLON) begin
            t.cls = CL_COLON;
            st = ST_SPACES;
          end else begin
            t.cls = CL_KEY;
          end
        end
        ST_SPACES: begin
          if (b == CH_SPACE) begin
            t.cls = CL_SKIP;
          end else if (b == CH_CR) begin
            t.cls = CL_VCR;
            st = ST_CR;
          end else begin
            t.cls = CL_VALUE;
            st = ST_VALUE;
          end
        end
        ST_VALUE: begin
          if (b == CH_CR) begin
            t.cls = CL_VCR;
            st = ST_CR;
          end else begin
            t.cls = CL_VALUE;
          end
        end
        ST_CR: begin
          if (b == CH_LF) begin
            t.cls = CL_COMMIT;
            st = ST_LF;
          end else begin
            t.bad = 1'b1;
            st = ST_BAD;
          end
        end
        ST_LF: begin
          if (b == CH_CR) begin
            t.cls = CL_HEND;
            st = ST_END_CR;
          end else begin
            t.cls = CL_KEY;
            st = ST_KEY;
          end
        end
        ST_END_CR: begin
          if (b == CH_LF) begin
            t.cls = CL_HEND;
            st = ST_BODY;
          end else begin
            t.bad = 1'b1;
            st = ST_BAD;
          end
        end
        default: begin
          t.cls = CL_BODY;
        end
      endcase
    end
    // end of buffer always returns to the start state
    if (l) st = ST_START;
    nxt = st;
    return t;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    tag_t   t;
    tag_t   want;
    state_t nxt;
    if (rst) begin
      parse_st <= ST_START;
      tags_due.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        t = tag_byte(in_ch.data_byte, in_ch.first_byte, in_ch.last_byte, parse_st, nxt);
        tags_due.push_back(t);
        parse_st <= nxt;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (tags_due.size() == 0) begin
          $display("%0t: result with nothing expected, actual byte %0h class %0h",
                   $time, out_ch.echo_byte, out_ch.byte_class);
          errors++;
        end else begin
          want = tags_due.pop_front();
          check_field("echo_byte", want.echo, out_ch.echo_byte);
          check_field("byte_class", want.cls, out_ch.byte_class);
          check_field("malformed", want.bad, out_ch.malformed);
          check_field("end_of_buffer", want.eob, out_ch.end_of_buffer);
        end
      end
    end
    pending = tags_due.size();
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
module tb;
  import hhlp_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int ItemTarget = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   err_cnt;
  int   outstanding;
  int   cycles = 0;
  int   items_sent = 0;
  int   stall_left = 0;
  bit   steady = 1'b0;

  always #2 clk = ~clk;

  hhlp_in_if  in_ch ();
  hhlp_out_if out_ch ();

  http_header_line_parser_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hhlp_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (err_cnt),
    .pending (outstanding)
  );

  // mostly short idles, now and then a long one
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 48);
  endfunction

  function automatic byte_t plain_byte();
    byte_t b;
    do begin
      b = byte_t'($urandom_range(1, 255));
    end while (b == CH_CR || b == CH_LF || b == CH_COLON || b == CH_SPACE);
    return b;
  endfunction

  function automatic byte_t noise_byte();
    case ($urandom_range(0, 5))
      0: return CH_NUL;
      1: return CH_CR;
      2: return CH_LF;
      3: return CH_COLON;
      4: return CH_SPACE;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = idle_len();
    end
  end

  task automatic send_byte(input byte_t b, input logic f, input logic l);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.first_byte <= f;
    in_ch.last_byte  <= l;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // hold the sender until every result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic send_buffer();
    byte_t bytes[$];
    byte_t b;
    int    n_lines;
    int    i;
    int    k;
    logic  restart;
    restart = ($urandom_range(0, 9) < 7);
    repeat ($urandom_range(0, 2)) bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    n_lines = $urandom_range(0, 4);
    for (i = 0; i < n_lines; i++) begin
      repeat ($urandom_range(1, 5)) bytes.push_back(plain_byte());
      bytes.push_back(CH_COLON);
      repeat ($urandom_range(0, 2)) bytes.push_back(CH_SPACE);
      repeat ($urandom_range(0, 6)) bytes.push_back(plain_byte());
      bytes.push_back(CH_CR);
      bytes.push_back(CH_LF);
    end
    if ($urandom_range(0, 9) < 8) begin
      bytes.push_back(CH_CR);
      bytes.push_back(CH_LF);
      repeat ($urandom_range(0, 8)) bytes.push_back(byte_t'($urandom_range(1, 255)));
    end
    if (bytes.size() == 0) bytes.push_back(plain_byte());
    // truncate now and then
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(1, bytes.size());
      while (bytes.size() > k) void'(bytes.pop_back());
    end
    for (i = 0; i < bytes.size(); i++) begin
      b = bytes[i];
      if ($urandom_range(0, 99) < 3) b = noise_byte();
      send_byte(b, (i == 0) ? restart : ($urandom_range(0, 199) == 0),
                i == bytes.size() - 1);
    end
  endtask

  initial begin : stimulus
    int n_buf;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.first_byte = 1'b0;
    in_ch.last_byte  = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // leading CR/LF, colon as first key byte, spaces, blank line, body, zero in body
    send_byte(CH_CR, 1'b1, 1'b0);
    send_byte(CH_LF, 1'b0, 1'b0);
    send_byte(CH_COLON, 1'b0, 1'b0);
    send_byte(8'h6B, 1'b0, 1'b0);
    send_byte(CH_COLON, 1'b0, 1'b0);
    send_byte(CH_SPACE, 1'b0, 1'b0);
    send_byte(CH_SPACE, 1'b0, 1'b0);
    send_byte(8'h76, 1'b0, 1'b0);
    send_byte(CH_CR, 1'b0, 1'b0);
    send_byte(CH_LF, 1'b0, 1'b0);
    send_byte(CH_CR, 1'b0, 1'b0);
    send_byte(CH_LF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(CH_NUL, 1'b0, 1'b0);
    send_byte(8'h78, 1'b0, 1'b1);
    // no restart flag: empty value, then a broken CRLF pair
    send_byte(8'h61, 1'b0, 1'b0);
    send_byte(CH_COLON, 1'b0, 1'b0);
    send_byte(CH_CR, 1'b0, 1'b0);
    send_byte(8'h7A, 1'b0, 1'b0);
    send_byte(CH_NUL, 1'b0, 1'b1);
    // broken blank line, then a zero byte in the start state
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(CH_COLON, 1'b0, 1'b0);
    send_byte(CH_CR, 1'b0, 1'b0);
    send_byte(CH_LF, 1'b0, 1'b0);
    send_byte(CH_CR, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b1);
    send_byte(CH_NUL, 1'b1, 1'b1);
    drain();

    n_buf = 0;
    while (items_sent < ItemTarget) begin
      steady = ($urandom_range(0, 7) == 0);
      send_buffer();
      n_buf++;
      if (n_buf % 40 == 0) drain();
    end
    steady = 1'b0;
    drain();
    repeat (8) @(negedge clk);

    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/hhlp_pkg.sv
hdl/hhlp_in_if.sv
hdl/hhlp_out_if.sv
hdl/http_header_line_parser_top.sv
bench/hhlp_checker.sv
bench/tb.sv
